/* rtl/srsw_pkg.sv */
`default_nettype none

package srsw_pkg;

    // Fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int ACK_SEQ_W  = 8;
    localparam int COUNT_W    = 24;
    localparam int TIMER_W    = 16;
    localparam int SEQ_W      = 4;
    localparam int INDEX_W    = 24;
    localparam int END_W      = 5;
    localparam int BASE_IDX_W = 25;

    // Stream and config port widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd20;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PACKET_COUNT  = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_SEND = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

endpackage

`default_nettype wire

/* rtl/srsw_timer_ram.sv */
`default_nettype none

// Per-sequence-number wait timers: one write port, one registered read port.
module srsw_timer_ram
    import srsw_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [TIMER_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic      [TIMER_W-1:0] o_rd_data
);

    logic [TIMER_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/selective_repeat_sender_window.sv */
`default_nettype none

// Selective-repeat ARQ sender window. Start and ack items are handled in idle.
// A tick is run by a small sequencer around one timer incrementer/comparator:
// it slides past acknowledged entries (at most WINDOW), stops the slide, makes
// the end check, then walks the window entries for aging and send requests,
// closes the walk and releases the final result. The input is held until the
// tick is through; a tick that ends the run goes from the end check to the end
// result. Result-side stalls lengthen both.
// Timers live in a RAM with a registered read and per-entry valid flags, so a
// start clears everything through the flags, with no clearing pass.
module selective_repeat_sender_window
    import srsw_pkg::*;
#(
    parameter int SEQ_SPACE = 16,
    parameter int WINDOW    = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: ack_seq[7:0]
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [OPCODE_W-1:0]   i_s_axis_tuser,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: seq[3:0], packet_index[27:4], end_marker[32:28], zero pad[39:33]
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: kind[0]
    output logic                       o_m_axis_tuser,
    output logic                       o_m_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SW = $clog2(SEQ_SPACE);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int EW = SW + 1;
    localparam int PAD_W = M_TDATA_W - SEQ_W - INDEX_W - END_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLIDE,
        S_CHECK,
        S_WALK,
        S_FLUSH,
        S_END
    } t_state;

    t_state               r_state;
    logic [COUNT_W-1:0]   r_packet_count;
    logic [TIMER_W-1:0]   r_timeout_ticks;
    logic [SEQ_SPACE-1:0] r_acked;
    logic [SEQ_SPACE-1:0] r_sent;
    logic [SEQ_SPACE-1:0] r_tvalid;
    logic [SW-1:0]        r_base_seq;
    logic [BASE_IDX_W-1:0] r_base_idx;
    logic                 r_finished;
    logic [SW-1:0]        r_slot;
    logic [SW-1:0]        n_slot;
    logic [CW-1:0]        r_cnt;
    logic [BASE_IDX_W-1:0] r_idx;

    logic                 r_pend_valid;
    logic [SW-1:0]        r_pend_slot;
    logic [INDEX_W-1:0]   r_pend_idx;

    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [SEQ_W-1:0]     r_out_seq;
    logic [INDEX_W-1:0]   r_out_idx;
    logic [END_W-1:0]     r_out_end;
    logic                 r_out_last;

    logic [TIMER_W-1:0]   w_timer_q;
    logic [SW-1:0]        w_slot_inc;
    logic                 w_in_accept;
    t_opcode              w_op;
    logic                 w_slide_step;
    logic                 w_walk_end;
    logic                 w_in_range;
    logic [TIMER_W-1:0]   w_tmr;
    logic [TIMER_W-1:0]   w_tnext;
    logic                 w_age;
    logic                 w_timeout;
    logic                 w_emit;
    logic                 w_out_free;
    logic                 w_stall;
    logic                 w_walk_go;
    logic                 w_tmr_we;
    logic                 w_out_load;
    logic [EW-1:0]        w_end_sum;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op        = t_opcode'(i_s_axis_tuser);
    assign w_slot_inc  = (r_slot == SW'(SEQ_SPACE - 1)) ? '0 : r_slot + 1'b1;

    assign w_slide_step = (r_cnt != CW'(WINDOW)) && r_acked[r_slot];
    assign w_walk_end   = (r_cnt == CW'(WINDOW));

    // Shared per-entry unit: index compare, timer increment and timeout compare
    assign w_in_range = r_idx < {1'b0, r_packet_count};
    assign w_tmr      = r_tvalid[r_slot] ? w_timer_q : '0;
    assign w_tnext    = w_tmr + 1'b1;
    assign w_age      = w_in_range && !r_acked[r_slot];
    assign w_timeout  = w_age && (w_tnext >= r_timeout_ticks);
    assign w_emit     = w_in_range && !(r_sent[r_slot] && !w_timeout);

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_stall    = w_emit && r_pend_valid && !w_out_free;
    assign w_walk_go  = (r_state == S_WALK) && !w_walk_end && !w_stall;
    assign w_tmr_we   = w_walk_go && !w_emit && w_age;

    // Output register is loaded this cycle
    assign w_out_load = (w_walk_go && w_emit && r_pend_valid)
                     || ((r_state == S_FLUSH) && r_pend_valid && w_out_free)
                     || ((r_state == S_END) && w_out_free);

    assign w_end_sum  = {1'b0, r_base_seq} + 1'b1;

    // Read address is the next slot so timer data lines up with r_slot
    always_comb begin
        case (r_state)
            S_IDLE:  n_slot = r_base_seq;
            S_SLIDE: n_slot = w_slide_step ? w_slot_inc : r_slot;
            S_WALK:  n_slot = w_walk_go ? w_slot_inc : r_slot;
            default: n_slot = r_slot;
        endcase
    end

    srsw_timer_ram #(
        .DEPTH (SEQ_SPACE),
        .AW    (SW)
    ) u_timer_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_tmr_we),
        .i_wr_addr (r_slot),
        .i_wr_data (w_tnext),
        .i_rd_addr (n_slot),
        .o_rd_data (w_timer_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_packet_count  <= '0;
            r_timeout_ticks <= TIMEOUT_RESET;
            r_acked         <= '0;
            r_sent          <= '0;
            r_tvalid        <= '0;
            r_base_seq      <= '0;
            r_base_idx      <= '0;
            r_finished      <= 1'b0;
            r_pend_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    REG_PACKET_COUNT:  r_packet_count  <= i_cfg_wdata[COUNT_W-1:0];
                    REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_wdata[TIMER_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_in_accept) begin
                        case (w_op)
                            OP_START: begin
                                r_acked    <= '0;
                                r_sent     <= '0;
                                r_tvalid   <= '0;
                                r_base_seq <= '0;
                                r_base_idx <= '0;
                                r_finished <= 1'b0;
                            end
                            OP_ACK: begin
                                if (!r_finished &&
                                    ({1'b0, i_s_axis_tdata} < (ACK_SEQ_W + 1)'(SEQ_SPACE))) begin
                                    r_acked[i_s_axis_tdata[SW-1:0]] <= 1'b1;
                                end
                            end
                            OP_TICK: begin
                                if (!r_finished) begin
                                    r_state <= S_SLIDE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_SLIDE: begin
                    if (w_slide_step) begin
                        r_acked[r_slot]  <= 1'b0;
                        r_sent[r_slot]   <= 1'b0;
                        r_tvalid[r_slot] <= 1'b0;
                        r_cnt            <= r_cnt + 1'b1;
                        r_base_idx       <= r_base_idx + 1'b1;
                    end else begin
                        r_base_seq <= r_slot;
                        r_state    <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    r_cnt <= '0;
                    r_idx <= r_base_idx;
                    if (r_base_idx >= {1'b0, r_packet_count}) begin
                        r_state <= S_END;
                    end else begin
                        r_state <= S_WALK;
                    end
                end

                S_WALK: begin
                    if (w_walk_end) begin
                        r_state <= S_FLUSH;
                    end else if (!w_stall) begin
                        if (w_emit) begin
                            r_sent[r_slot]   <= 1'b1;
                            r_tvalid[r_slot] <= 1'b0;
                            // previous send request is known not to be last
                            if (r_pend_valid) begin
                                r_out_kind  <= KIND_SEND;
                                r_out_seq   <= SEQ_W'(r_pend_slot);
                                r_out_idx   <= r_pend_idx;
                                r_out_end   <= '0;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_slot  <= r_slot;
                            r_pend_idx   <= r_idx[INDEX_W-1:0];
                        end else if (w_age) begin
                            r_tvalid[r_slot] <= 1'b1;
                        end
                        r_cnt <= r_cnt + 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end

                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_kind   <= KIND_SEND;
                        r_out_seq    <= SEQ_W'(r_pend_slot);
                        r_out_idx    <= r_pend_idx;
                        r_out_end    <= '0;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end

                S_END: begin
                    if (w_out_free) begin
                        r_out_kind  <= KIND_END;
                        r_out_seq   <= '0;
                        r_out_idx   <= '0;
                        r_out_end   <= END_W'(w_end_sum);
                        r_out_last  <= 1'b1;
                        r_finished  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_end, r_out_idx, r_out_seq};

    // A held send request never survives into idle
    a_pend_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending send request left over after tick");

    // Finishing always loads the end result
    a_finish_emits_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_finished) |-> (r_out_valid && r_out_kind == KIND_END && r_out_last))
        else $error("finished set without end result");

    // No aging or sending once the transfer is finished
    a_no_walk_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_SLIDE) |-> !r_finished)
        else $error("tick work while finished");

    // Walk counter stays within the window
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLIDE || r_state == S_WALK) |-> (r_cnt <= CW'(WINDOW)))
        else $error("window counter overrun");

    // Slot pointer stays inside the sequence space
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ({1'b0, r_slot} < (SW + 1)'(SEQ_SPACE)))
        else $error("slot pointer out of range");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
    import srsw_pkg::*;

    localparam int SEQ_SPACE   = 16;
    localparam int WINDOW      = 8;
    // one tick slides past and walks at most 2*WINDOW entries in all, plus control states
    localparam int SETTLE      = 2 * WINDOW + 24;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [OPCODE_W-1:0] OP_BAD = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]  op;
        logic [ACK_SEQ_W-1:0] ack;
    } arq_event_t;

    typedef struct packed {
        t_kind              kind;
        logic [SEQ_W-1:0]   seq;
        logic [INDEX_W-1:0] idx;
        logic [END_W-1:0]   endm;
        logic               last;
    } arq_result_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic [OPCODE_W-1:0]   in_op     = '0;
    logic [S_TDATA_W-1:0]  in_ack    = '0;
    logic                  in_valid  = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_ready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;

    // stimulus and expectation stores
    arq_event_t  arq_events[$];
    arq_result_t due_results[$];
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    int          tx_wait;
    int          rx_wait;
    bit          idle_on  = 1'b1;
    bit          hold_go  = 1'b0;
    logic        rx_block = 1'b0;

    // predicted window state
    logic [TIMER_W-1:0]    timer_m[SEQ_SPACE];
    bit                    ackd[SEQ_SPACE];
    bit                    sent[SEQ_SPACE];
    logic [SEQ_W-1:0]      base_seq  = '0;
    logic [BASE_IDX_W-1:0] base_idx  = '0;
    bit                    done_flag = 1'b0;
    logic [COUNT_W-1:0]    cfg_pkt_cnt = '0;
    logic [TIMER_W-1:0]    cfg_timeout = TIMEOUT_RESET;

    selective_repeat_sender_window #(
        .SEQ_SPACE(SEQ_SPACE),
        .WINDOW   (WINDOW)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tdata (in_ack),
        .i_s_axis_tuser (in_op),
        .i_s_axis_tvalid(in_valid),
        .o_s_axis_tready(s_ready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(out_ready),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        for (int j = 0; j < SEQ_SPACE; j++) begin
            timer_m[j] = '0;
            ackd[j]    = 1'b0;
            sent[j]    = 1'b0;
        end
    end

    function automatic void clear_window();
        for (int j = 0; j < SEQ_SPACE; j++) begin
            timer_m[j] = '0;
            ackd[j]    = 1'b0;
            sent[j]    = 1'b0;
        end
        base_seq  = '0;
        base_idx  = '0;
        done_flag = 1'b0;
    endfunction

    // advance the predicted window by one accepted transfer
    function automatic void window_step(logic [OPCODE_W-1:0] op, logic [ACK_SEQ_W-1:0] ack);
        int          n;
        bit          stop;
        logic [3:0]  s;
        logic [25:0] idx;
        arq_result_t r;
        arq_result_t burst[$];
        if (op == OP_START) begin
            clear_window();
            return;
        end
        if (done_flag || op == OP_BAD)
            return;
        if (op == OP_ACK) begin
            if (ack < SEQ_SPACE)
                ackd[ack[SEQ_W-1:0]] = 1'b1;
            return;
        end
        n    = 0;
        stop = 1'b0;
        for (int j = 0; j < WINDOW; j++) begin
            s = 4'(base_seq + j);
            if (!stop && ackd[s]) begin
                ackd[s]    = 1'b0;
                sent[s]    = 1'b0;
                timer_m[s] = '0;
                n++;
            end else begin
                stop = 1'b1;
            end
        end
        base_seq = 4'(base_seq + n);
        base_idx = 25'(base_idx + n);
        if (base_idx >= cfg_pkt_cnt) begin
            done_flag = 1'b1;
            r.kind = KIND_END;
            r.seq  = '0;
            r.idx  = '0;
            r.endm = 5'(base_seq) + 5'd1;
            r.last = 1'b1;
            due_results.push_back(r);
            return;
        end
        for (int j = 0; j < WINDOW; j++) begin
            s   = 4'(base_seq + j);
            idx = 26'(base_idx) + 26'(j);
            if (idx < cfg_pkt_cnt && !ackd[s]) begin
                timer_m[s] = timer_m[s] + 16'd1;
                if (timer_m[s] >= cfg_timeout) begin
                    timer_m[s] = '0;
                    sent[s]    = 1'b0;
                end
            end
        end
        for (int j = 0; j < WINDOW; j++) begin
            s   = 4'(base_seq + j);
            idx = 26'(base_idx) + 26'(j);
            if (!sent[s] && idx < cfg_pkt_cnt) begin
                sent[s]    = 1'b1;
                timer_m[s] = '0;
                r.kind = KIND_SEND;
                r.seq  = s;
                r.idx  = idx[INDEX_W-1:0];
                r.endm = '0;
                r.last = 1'b0;
                burst.push_back(r);
            end
        end
        foreach (burst[k]) begin
            r      = burst[k];
            r.last = (k == burst.size() - 1);
            due_results.push_back(r);
        end
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // input side: one transfer per accepted event, random gap after each when idle gaps are on
    always @(posedge clk) begin : drive_proc
        arq_event_t ev;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end else if (!in_valid || s_ready) begin
            if (in_valid) begin
                window_step(in_op, in_ack);
                tx_wait = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (tx_wait > 0) begin
                tx_wait = tx_wait - 1;
                in_valid <= 1'b0;
            end else if (arq_events.size() != 0) begin
                ev = arq_events.pop_front();
                in_op    <= ev.op;
                in_ack   <= ev.ack;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: compare each transfer against the oldest prediction
    always @(posedge clk) begin : check_proc
        arq_result_t want;
        bit          bad;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && out_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result tuser=%0b tdata=%h tlast=%0b",
                                            m_tuser, m_tdata, m_tlast));
                end else begin
                    want = due_results.pop_front();
                    bad = (m_tuser !== want.kind) || (m_tdata[3:0] !== want.seq)
                        || (m_tdata[27:4] !== want.idx) || (m_tdata[32:28] !== want.endm)
                        || (m_tlast !== want.last) || (m_tdata[39:33] !== '0);
                    if (bad)
                        flag_mismatch($sformatf({"expected kind=%0d seq=%0d index=%0d ",
                            "end=%0d last=%0b, got kind=%0d seq=%0d index=%0d end=%0d ",
                            "last=%0b pad=%h"}, want.kind, want.seq, want.idx, want.endm,
                            want.last, m_tuser, m_tdata[3:0], m_tdata[27:4],
                            m_tdata[32:28], m_tlast, m_tdata[39:33]));
                end
                rx_wait = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (rx_block || rx_wait > 0) begin
                if (rx_wait > 0)
                    rx_wait = rx_wait - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_block <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_block <= 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && s_ready) || (m_tvalid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_event(logic [OPCODE_W-1:0] op, logic [ACK_SEQ_W-1:0] ack);
        arq_event_t ev;
        while (arq_events.size() > 2)
            @(posedge clk);
        ev.op  = op;
        ev.ack = ack;
        arq_events.push_back(ev);
    endtask

    task automatic drain();
        while (arq_events.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(t_cfg_reg sel, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            REG_PACKET_COUNT:  cfg_pkt_cnt = value;
            REG_TIMEOUT_TICKS: cfg_timeout = value[TIMER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(logic [COUNT_W-1:0] pkts, logic [TIMER_W-1:0] tmo,
                             int n_items, bit idle, bit hold, bit pause_mid);
        int r;
        cfg_write(REG_PACKET_COUNT, pkts);
        cfg_write(REG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
        idle_on = idle;
        push_event(OP_START, 8'($urandom()));
        if (hold)
            hold_go = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (pause_mid && k == n_items / 2)
                drain();
            // a finished window ignores everything but start
            if (done_flag)
                push_event(OP_START, 8'($urandom()));
            r = $urandom_range(0, 99);
            if (r < 4)
                push_event(OP_BAD, 8'($urandom()));
            else if (r < 7)
                push_event(OP_ACK, 8'($urandom_range(SEQ_SPACE, 255)));
            else if (r < 9)
                push_event(OP_START, 8'($urandom()));
            else if (r < 45)
                push_event(OP_TICK, 8'($urandom()));
            else if (r < 90)
                push_event(OP_ACK, 8'(4'(base_seq + $urandom_range(0, WINDOW - 1))));
            else
                push_event(OP_ACK, 8'($urandom_range(0, SEQ_SPACE - 1)));
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero packets, end on first tick, then ignored until start
        push_event(OP_TICK, 8'h00);
        push_event(OP_TICK, 8'hFF);
        push_event(OP_ACK, 8'h03);
        push_event(OP_BAD, 8'hAA);
        push_event(OP_START, 8'h55);
        push_event(OP_TICK, 8'h00);
        drain();

        // three packets, timeout on every tick, acks out of range and ahead of window
        cfg_write(REG_PACKET_COUNT, 24'd3);
        cfg_write(REG_TIMEOUT_TICKS, 24'd1);
        push_event(OP_START, 8'h00);
        push_event(OP_TICK, 8'h00);
        push_event(OP_ACK, 8'h01);
        push_event(OP_ACK, 8'hFF);
        push_event(OP_ACK, 8'h0A);
        push_event(OP_TICK, 8'h00);
        push_event(OP_ACK, 8'h00);
        push_event(OP_ACK, 8'h02);
        push_event(OP_TICK, 8'h00);
        push_event(OP_BAD, 8'h00);
        push_event(OP_TICK, 8'h00);
        push_event(OP_START, 8'h00);
        drain();

        // maximum count and timeout
        cfg_write(REG_PACKET_COUNT, 24'hFFFFFF);
        cfg_write(REG_TIMEOUT_TICKS, 24'hFFFF);
        push_event(OP_START, 8'h00);
        push_event(OP_TICK, 8'h00);
        push_event(OP_ACK, 8'h00);
        push_event(OP_ACK, 8'h01);
        push_event(OP_TICK, 8'h00);
        drain();

        run_phase(24'd5,        16'd2,     28, 1'b1, 1'b0, 1'b0);
        run_phase(24'd12,       16'd3,     28, 1'b0, 1'b0, 1'b0);
        run_phase(24'hFFFFFF,   16'hFFFF,  24, 1'b1, 1'b1, 1'b0);
        run_phase(24'd1,        16'd1,     18, 1'b1, 1'b0, 1'b0);
        run_phase(24'd20,       16'd4,     32, 1'b1, 1'b0, 1'b1);
        run_phase(24'd9,        16'd0,     24, 1'b1, 1'b0, 1'b0);
        run_phase(24'hFFFFFF,   16'd6,     28, 1'b1, 1'b0, 1'b0);
        run_phase(24'd40,       16'd20,    24, 1'b1, 1'b0, 1'b0);

        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
